// File: sv/lfxc_pkg.sv
// Shared types and constants for the line checksum checker.
// Used by lfxc_front, lfxc_queue, lfxc_back and the top level.
// No dependencies.
package lfxc_pkg;

    // Line buffer limit and the width of the held byte counter
    localparam int unsigned HELD_W = 8;
    localparam logic [HELD_W-1:0] LINE_LIMIT = 8'd128;
    localparam logic [HELD_W-1:0] LIMIT_LAST = LINE_LIMIT - 8'd1;

    // Characters with special meaning
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_STAR = 8'h2A;
    localparam logic [7:0] CH_NUL  = 8'h00;

    // What the back end does with one queued entry
    typedef enum logic [1:0] {
        K_BYTE  = 2'd0,   // content byte
        K_EMIT  = 2'd1,   // newline: emit verdict, then clear
        K_CLEAR = 2'd2    // line overflow: clear silently
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;
    } t_item;

    // Queue status seen by front and back
    typedef struct packed {
        logic full;
        logic not_empty;
    } t_q_stat;

endpackage

// File: sv/lfxc_front.sv
// Front end: accepts received bytes, tracks the line length and classifies
// each byte into a queue entry. Depends on lfxc_pkg.
module lfxc_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [7:0]        i_rx_byte,
    input  lfxc_pkg::t_q_stat i_q_stat,
    output logic              o_stall,
    output logic              o_push,
    output lfxc_pkg::t_item   o_item
);
    import lfxc_pkg::*;

    logic [HELD_W-1:0] r_held;
    logic [HELD_W-1:0] n_held;
    logic              accept;
    logic              is_lf;
    logic              is_over;
    logic              is_cr;

    assign o_stall = i_q_stat.full;
    assign accept  = i_valid && !i_q_stat.full;
    assign is_lf   = (i_rx_byte == CH_LF);
    assign is_over = !is_lf && (r_held >= LIMIT_LAST);
    assign is_cr   = !is_lf && !is_over && (i_rx_byte == CH_CR);

    // Classification; carriage returns reach the queue only as overflow clears
    always_comb begin
        o_item.data = i_rx_byte;
        priority if (is_lf) begin
            o_item.kind = K_EMIT;
        end else if (is_over) begin
            o_item.kind = K_CLEAR;
        end else begin
            o_item.kind = K_BYTE;
        end
        o_push = accept && !is_cr;
    end

    // Held byte count
    always_comb begin
        n_held = r_held;
        if (accept) begin
            priority if (is_lf || is_over) begin
                n_held = '0;
            end else if (!is_cr) begin
                n_held = r_held + HELD_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= '0;
        end else begin
            r_held <= n_held;
        end
    end

endmodule

// File: sv/lfxc_queue.sv
// Two-entry queue between the front and back ends.
// Depends on lfxc_pkg.
module lfxc_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  lfxc_pkg::t_item   i_item,
    input  logic              i_pop,
    output lfxc_pkg::t_item   o_head,
    output lfxc_pkg::t_q_stat o_stat
);
    import lfxc_pkg::*;

    t_item      r_slot [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic [1:0] n_count;

    assign o_head           = r_slot[r_rd_ptr];
    assign o_stat.full      = (r_count == 2'd2);
    assign o_stat.not_empty = (r_count != 2'd0);

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 2'd1;
        end
    end

    // Pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_item;
        end
    end

endmodule

// File: sv/lfxc_back.sv
// Back end: applies queued entries to the line state (XOR sum, marker,
// hex checksum parser) and holds the verdict in an output register.
// Depends on lfxc_pkg.
module lfxc_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lfxc_pkg::t_item   i_head,
    input  lfxc_pkg::t_q_stat i_q_stat,
    output logic              o_pop,
    input  logic              i_stall,
    output logic              o_valid,
    output logic              o_frame_ok,
    output logic              o_marker_seen,
    output logic [7:0]        o_sum_computed,
    output logic [7:0]        o_sum_given
);
    import lfxc_pkg::*;

    // Hex parser phases
    typedef enum logic [5:0] {
        PH_BLANK  = 6'b000001,
        PH_SIGN   = 6'b000010,
        PH_ZERO   = 6'b000100,
        PH_PREFIX = 6'b001000,
        PH_DIGITS = 6'b010000,
        PH_STOP   = 6'b100000
    } t_phase;

    // Bit 4 set when the byte is not a hex digit
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] v;
        v = 5'd16;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = {1'b0, c[3:0]};
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            v = {1'b0, c[3:0] + 4'd9};
        end
        return v;
    endfunction

    logic [7:0] r_xor;
    logic [7:0] n_xor;
    logic       r_marker;
    logic       n_marker;
    logic       r_ended;
    logic       n_ended;
    t_phase     r_phase;
    t_phase     n_phase;
    logic [7:0] r_hex;
    logic [7:0] n_hex;
    logic       r_neg;
    logic       n_neg;
    logic       r_out_valid;
    logic       r_ok;
    logic       r_seen;
    logic [7:0] r_sum_c;
    logic [7:0] r_sum_g;
    logic [7:0] given;
    logic [4:0] dval;
    logic       is_blank;
    logic [7:0] c;

    assign c = i_head.data;

    // Take an entry unless it is a verdict and the output is blocked
    assign o_pop = i_q_stat.not_empty &&
                   (i_head.kind != K_EMIT || !r_out_valid || !i_stall);

    assign given    = r_marker ? (r_neg ? (8'd0 - r_hex) : r_hex) : 8'd0;
    assign dval     = hex_value(c);
    assign is_blank = (c == 8'h20) || (c == 8'h09) || (c == 8'h0B) || (c == 8'h0C);

    // Line state update
    always_comb begin
        n_xor    = r_xor;
        n_marker = r_marker;
        n_ended  = r_ended;
        n_phase  = r_phase;
        n_hex    = r_hex;
        n_neg    = r_neg;
        if (o_pop) begin
            unique case (i_head.kind)
                K_EMIT, K_CLEAR: begin
                    n_xor    = '0;
                    n_marker = 1'b0;
                    n_ended  = 1'b0;
                    n_phase  = PH_BLANK;
                    n_hex    = '0;
                    n_neg    = 1'b0;
                end
                K_BYTE: begin
                    priority if (r_ended) begin
                        n_ended = 1'b1;
                    end else if (c == CH_NUL) begin
                        n_ended = 1'b1;
                    end else if (!r_marker) begin
                        if (c == CH_STAR) begin
                            n_marker = 1'b1;
                        end else begin
                            n_xor = r_xor ^ c;
                        end
                    end else begin
                        // checksum text after the marker
                        unique case (r_phase)
                            PH_BLANK, PH_SIGN: begin
                                priority if (r_phase == PH_BLANK && is_blank) begin
                                    n_phase = PH_BLANK;
                                end else if (r_phase == PH_BLANK && c == 8'h2B) begin
                                    n_phase = PH_SIGN;
                                end else if (r_phase == PH_BLANK && c == 8'h2D) begin
                                    n_neg   = 1'b1;
                                    n_phase = PH_SIGN;
                                end else if (c == 8'h30) begin
                                    n_phase = PH_ZERO;
                                end else if (!dval[4]) begin
                                    n_hex   = {r_hex[3:0], dval[3:0]};
                                    n_phase = PH_DIGITS;
                                end else begin
                                    n_phase = PH_STOP;
                                end
                            end
                            PH_ZERO: begin
                                priority if (c == 8'h78 || c == 8'h58) begin
                                    n_phase = PH_PREFIX;
                                end else if (!dval[4]) begin
                                    n_hex   = {r_hex[3:0], dval[3:0]};
                                    n_phase = PH_DIGITS;
                                end else begin
                                    n_phase = PH_STOP;
                                end
                            end
                            PH_PREFIX, PH_DIGITS: begin
                                if (!dval[4]) begin
                                    n_hex   = {r_hex[3:0], dval[3:0]};
                                    n_phase = PH_DIGITS;
                                end else begin
                                    n_phase = PH_STOP;
                                end
                            end
                            PH_STOP: begin
                                n_phase = PH_STOP;
                            end
                            default: begin
                                n_phase = PH_STOP;
                            end
                        endcase
                    end
                end
                default: begin
                    n_xor = r_xor;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_xor       <= '0;
            r_marker    <= 1'b0;
            r_ended     <= 1'b0;
            r_phase     <= PH_BLANK;
            r_hex       <= '0;
            r_neg       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_xor    <= n_xor;
            r_marker <= n_marker;
            r_ended  <= n_ended;
            r_phase  <= n_phase;
            r_hex    <= n_hex;
            r_neg    <= n_neg;
            if (o_pop && i_head.kind == K_EMIT) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Verdict register
    always_ff @(posedge i_clk) begin
        if (o_pop && i_head.kind == K_EMIT) begin
            r_ok    <= r_marker && (given == r_xor);
            r_seen  <= r_marker;
            r_sum_c <= r_xor;
            r_sum_g <= given;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_frame_ok     = r_ok;
    assign o_marker_seen  = r_seen;
    assign o_sum_computed = r_sum_c;
    assign o_sum_given    = r_sum_g;

endmodule

// File: sv/line_frame_xor_checksum_check.sv
// Line checksum checker, top level.
// Depends on lfxc_pkg, lfxc_front, lfxc_queue and lfxc_back.
//
// Input channel: one received byte per transaction on i_rx_byte, taken when
// i_valid is high and o_stall is low. Carriage returns are dropped; a line
// that reaches the buffer limit is thrown away.
// Output channel: one verdict per newline (o_frame_ok, o_marker_seen,
// o_sum_computed, o_sum_given), taken when o_valid is high and i_stall low.
// Throughput: one byte per cycle while o_stall is low. The front end classifies a
// byte in the cycle it is taken, a two-entry queue holds it, and the back end
// applies it to the line state once it is popped from the queue head.
// Verdict path: a taken newline enters the queue and is popped into the verdict
// register that drives o_valid; it waits in the queue while that register is blocked.
// Stalls: while i_stall holds the verdict register, non-newline bytes keep
// flowing; a second newline waits in the queue, and o_stall rises once the
// queue is full.
// Reset (synchronous, active low) empties the queue, drops any pending
// verdict and clears the line state; the block accepts bytes right after.
module line_frame_xor_checksum_check (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_rx_byte,
    output logic       o_valid,
    input  logic       i_stall,
    output logic       o_frame_ok,
    output logic       o_marker_seen,
    output logic [7:0] o_sum_computed,
    output logic [7:0] o_sum_given
);
    import lfxc_pkg::*;

    t_q_stat q_stat;
    t_item   push_item;
    t_item   head_item;
    logic    push;
    logic    pop;

    lfxc_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_rx_byte (i_rx_byte),
        .i_q_stat  (q_stat),
        .o_stall   (o_stall),
        .o_push    (push),
        .o_item    (push_item)
    );

    lfxc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .i_pop   (pop),
        .o_head  (head_item),
        .o_stat  (q_stat)
    );

    lfxc_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head         (head_item),
        .i_q_stat       (q_stat),
        .o_pop          (pop),
        .i_stall        (i_stall),
        .o_valid        (o_valid),
        .o_frame_ok     (o_frame_ok),
        .o_marker_seen  (o_marker_seen),
        .o_sum_computed (o_sum_computed),
        .o_sum_given    (o_sum_given)
    );

endmodule

// File: bench/tb_line_frame_xor_checksum_check.sv
// Self-checking bench for line_frame_xor_checksum_check: directed table, then random lines.
// Expected verdicts come from a behavioral line tracker here; pinned rows carry their own.
// Depends on lfxc_pkg and the line_frame_xor_checksum_check RTL.
module tb_line_frame_xor_checksum_check;
    import lfxc_pkg::*;

    localparam int HALF_PERIOD = 6;
    localparam int TIMEOUT_CYCLES = 200000;
    localparam int RANDOM_BYTES = 1350;

    // Characters used by the checksum text parser and the line generator
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_X_LO  = 8'h78;
    localparam logic [7:0] CH_X_UP  = 8'h58;
    localparam logic [7:0] CH_SEMI  = 8'h3B;

    typedef enum logic [5:0] {
        HX_BLANK  = 6'b000001,
        HX_SIGN   = 6'b000010,
        HX_ZERO   = 6'b000100,
        HX_PREFIX = 6'b001000,
        HX_DIGITS = 6'b010000,
        HX_STOP   = 6'b100000
    } t_hex_phase;

    typedef struct packed {
        logic       ok;
        logic       marker;
        logic [7:0] sum_comp;
        logic [7:0] sum_given;
    } t_verdict;

    // One byte to send; pinned rows carry a verdict typed in by hand,
    // hold makes the sender drain all outstanding verdicts first
    typedef struct packed {
        logic [7:0] code;
        logic       pinned;
        t_verdict   want;
        logic       hold;
    } t_stim;

    localparam t_verdict V_NONE   = '{1'b0, 1'b0, 8'h00, 8'h00};
    localparam t_verdict V_BARE   = '{1'b1, 1'b1, 8'h00, 8'h00};
    localparam t_verdict V_PREFIX = '{1'b0, 1'b1, 8'hFF, 8'h00};
    localparam t_verdict V_ENDED  = '{1'b0, 1'b0, 8'h41, 8'h00};

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic [7:0] i_rx_byte = 8'h00;
    logic       i_stall = 1'b0;
    logic       o_stall;
    logic       o_valid;
    logic       o_frame_ok;
    logic       o_marker_seen;
    logic [7:0] o_sum_computed;
    logic [7:0] o_sum_given;

    line_frame_xor_checksum_check u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_rx_byte      (i_rx_byte),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_frame_ok     (o_frame_ok),
        .o_marker_seen  (o_marker_seen),
        .o_sum_computed (o_sum_computed),
        .o_sum_given    (o_sum_given)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    t_stim      stim_q[$];
    t_verdict   pending_verdicts[$];
    t_stim      cur_tx;
    t_stim      dir_tab [23];

    int n_sent = 0;
    int n_rand = 0;
    int n_lines = 0;
    int n_checked = 0;
    int n_pass_sum = 0;
    int n_no_marker = 0;
    int n_overflow = 0;
    int n_err = 0;

    // Line tracker state
    logic [7:0] ln_count;
    logic [7:0] ln_xor;
    logic       ln_marker;
    logic       ln_ended;
    t_hex_phase hx_phase;
    logic [7:0] hx_acc;
    logic       hx_neg;

    task automatic line_clear();
        ln_count  = '0;
        ln_xor    = '0;
        ln_marker = 1'b0;
        ln_ended  = 1'b0;
        hx_phase  = HX_BLANK;
        hx_acc    = '0;
        hx_neg    = 1'b0;
    endtask

    // Advance the line tracker by one accepted byte; a newline yields a verdict
    task automatic apply_rx_byte(input logic [7:0] c, output bit emit, output t_verdict v);
        logic [7:0] given;
        logic [4:0] d;
        emit = 1'b0;
        v = '0;
        d = 5'd16;
        if (c >= "0" && c <= "9") d = 5'(c - "0");
        else if (c >= "a" && c <= "f") d = 5'(c - "a" + 8'd10);
        else if (c >= "A" && c <= "F") d = 5'(c - "A" + 8'd10);

        if (c == CH_LF) begin
            given = ln_marker ? (hx_neg ? 8'd0 - hx_acc : hx_acc) : 8'h00;
            v.ok = ln_marker && (given == ln_xor);
            v.marker = ln_marker;
            v.sum_comp = ln_xor;
            v.sum_given = given;
            emit = 1'b1;
            line_clear();
        end else if (ln_count >= LIMIT_LAST) begin
            // line too long: everything is dropped, this byte too
            line_clear();
            n_overflow++;
        end else if (c != CH_CR) begin
            ln_count = ln_count + 8'd1;
            if (!ln_ended) begin
                if (c == CH_NUL) begin
                    ln_ended = 1'b1;
                end else if (!ln_marker) begin
                    if (c == CH_STAR) ln_marker = 1'b1;
                    else ln_xor = ln_xor ^ c;
                end else if (hx_phase == HX_BLANK &&
                             (c == CH_SPACE || c == CH_TAB || c == CH_VT || c == CH_FF)) begin
                    hx_phase = HX_BLANK;
                end else if (hx_phase == HX_BLANK && c == CH_PLUS) begin
                    hx_phase = HX_SIGN;
                end else if (hx_phase == HX_BLANK && c == CH_MINUS) begin
                    hx_neg = 1'b1;
                    hx_phase = HX_SIGN;
                end else if ((hx_phase == HX_BLANK || hx_phase == HX_SIGN) && c == CH_ZERO) begin
                    hx_phase = HX_ZERO;
                end else if (hx_phase == HX_ZERO && (c == CH_X_LO || c == CH_X_UP)) begin
                    hx_phase = HX_PREFIX;
                end else if (hx_phase != HX_STOP && d < 5'd16) begin
                    hx_acc = {hx_acc[3:0], d[3:0]};
                    hx_phase = HX_DIGITS;
                end else begin
                    hx_phase = HX_STOP;
                end
            end
        end
    endtask

    task automatic put(input logic [7:0] b);
        t_stim s;
        s = '0;
        s.code = b;
        stim_q.push_back(s);
        if (b != CH_CR) n_rand++;
    endtask

    // One random line: mostly payload, marker and a matching checksum in
    // varied notation; some lines are noise, unmarked, broken or too long
    task automatic gen_line(input bit long_line);
        int len, kind, k, nd;
        logic [7:0] b, sum, val;
        logic [3:0] nib;
        bit neg, up;
        kind = $urandom_range(0, 99);
        neg = 1'b0;
        up = 1'($urandom_range(0, 1));
        if (!long_line && kind < 8) begin
            len = $urandom_range(1, 30);
            for (k = 0; k < len; k++) put(8'($urandom_range(0, 255)));
            put(CH_LF);
            return;
        end
        len = long_line ? $urandom_range(118, 132) : $urandom_range(0, 24);
        sum = '0;
        for (k = 0; k < len; k++) begin
            b = 8'($urandom_range(0, 255));
            if (b == CH_LF || b == CH_STAR || b == CH_NUL) b = b ^ 8'h80;
            if ($urandom_range(0, 29) == 0) b = CH_CR;
            if ($urandom_range(0, 79) == 0) b = CH_NUL;
            if (b != CH_CR) sum = sum ^ b;
            put(b);
        end
        if (kind < 14) begin
            put(CH_LF);
            return;
        end
        put(CH_STAR);
        // leading blanks
        if ($urandom_range(0, 3) == 0) begin
            for (k = $urandom_range(1, 3); k > 0; k--) begin
                case ($urandom_range(0, 3))
                    0: put(CH_SPACE);
                    1: put(CH_TAB);
                    2: put(CH_VT);
                    default: put(CH_FF);
                endcase
            end
        end
        case ($urandom_range(0, 9))
            0: put(CH_PLUS);
            1: begin
                put(CH_MINUS);
                neg = 1'b1;
            end
            default: ;
        endcase
        val = neg ? 8'd0 - sum : sum;
        if ($urandom_range(0, 9) == 0) val = val ^ 8'($urandom_range(1, 255));
        if ($urandom_range(0, 4) == 0) begin
            put(CH_ZERO);
            put(up ? CH_X_UP : CH_X_LO);
        end
        case ($urandom_range(0, 19))
            0: nd = 0;
            1, 2: nd = 1;
            3, 4: nd = $urandom_range(3, 5);
            default: nd = 2;
        endcase
        for (k = nd - 1; k >= 0; k--) begin
            nib = (k >= 2) ? 4'($urandom_range(0, 15)) : (k == 1 ? val[7:4] : val[3:0]);
            put(nib < 4'd10 ? CH_ZERO + nib : (up ? "A" : "a") + nib - 8'd10);
        end
        // trailing junk, later asterisks, zero bytes
        if ($urandom_range(0, 4) == 0) begin
            case ($urandom_range(0, 3))
                0: put(CH_STAR);
                1: put(CH_SEMI);
                2: put(CH_NUL);
                default: begin
                    b = 8'($urandom_range(0, 255));
                    put(b == CH_LF ? CH_SEMI : b);
                end
            endcase
        end
        if ($urandom_range(0, 2) == 0) put(CH_CR);
        put(CH_LF);
    endtask

    task automatic note_error(input string what);
        n_err++;
        if (n_err <= 10) $display("%0t mismatch: %s", $realtime, what);
    endtask

    function automatic bit quiet_span();
        return n_sent >= 700 && n_sent < 1000;
    endfunction

    // Sender: track accepted bytes, then present the next one
    always @(posedge i_clk) begin : sender
        t_verdict v;
        bit       got;
        t_stim    nxt;
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                apply_rx_byte(i_rx_byte, got, v);
                if (got) pending_verdicts.push_back(cur_tx.pinned ? cur_tx.want : v);
                n_sent++;
            end
            if (!i_valid || !o_stall) begin
                if (stim_q.size() == 0) begin
                    i_valid <= 1'b0;
                end else begin
                    nxt = stim_q[0];
                    if (nxt.hold && pending_verdicts.size() != 0) begin
                        i_valid <= 1'b0;
                    end else if (!quiet_span() && $urandom_range(0, 99) < 11) begin
                        i_valid <= 1'b0;
                    end else begin
                        cur_tx = stim_q.pop_front();
                        i_valid <= 1'b1;
                        i_rx_byte <= cur_tx.code;
                    end
                end
            end
        end
    end

    // Receiver: check each verdict transaction against the oldest expectation
    always @(posedge i_clk) begin : receiver
        t_verdict e;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (pending_verdicts.size() == 0) begin
                    note_error($sformatf("verdict with none expected: ok=%0b mk=%0b sc=%02h sg=%02h",
                        o_frame_ok, o_marker_seen, o_sum_computed, o_sum_given));
                end else begin
                    e = pending_verdicts.pop_front();
                    n_checked++;
                    if (e.ok) n_pass_sum++;
                    if (!e.marker) n_no_marker++;
                    if (o_frame_ok !== e.ok || o_marker_seen !== e.marker ||
                        o_sum_computed !== e.sum_comp || o_sum_given !== e.sum_given)
                        note_error($sformatf(
                            "exp ok=%0b mk=%0b sc=%02h sg=%02h, got ok=%0b mk=%0b sc=%02h sg=%02h",
                            e.ok, e.marker, e.sum_comp, e.sum_given,
                            o_frame_ok, o_marker_seen, o_sum_computed, o_sum_given));
                end
            end
            i_stall <= !quiet_span() && ($urandom_range(0, 99) < 11);
        end
    end

    // Directed lines: empty line, bare marker, sign and prefix with no
    // digit after 0xFF, zero byte before the marker, long checksum text
    // ended by a later asterisk
    initial begin
        dir_tab = '{
            '{CH_LF,    1'b1, V_NONE,   1'b0},
            '{CH_STAR,  1'b0, V_NONE,   1'b0},
            '{CH_LF,    1'b1, V_BARE,   1'b0},
            '{8'hFF,    1'b0, V_NONE,   1'b0},
            '{CH_CR,    1'b0, V_NONE,   1'b0},
            '{CH_STAR,  1'b0, V_NONE,   1'b0},
            '{CH_TAB,   1'b0, V_NONE,   1'b0},
            '{CH_MINUS, 1'b0, V_NONE,   1'b0},
            '{CH_ZERO,  1'b0, V_NONE,   1'b0},
            '{CH_X_LO,  1'b0, V_NONE,   1'b0},
            '{CH_LF,    1'b1, V_PREFIX, 1'b0},
            '{"A",      1'b0, V_NONE,   1'b1},
            '{CH_NUL,   1'b0, V_NONE,   1'b0},
            '{CH_STAR,  1'b0, V_NONE,   1'b0},
            '{"4",      1'b0, V_NONE,   1'b0},
            '{CH_LF,    1'b1, V_ENDED,  1'b0},
            '{"3",      1'b0, V_NONE,   1'b0},
            '{CH_STAR,  1'b0, V_NONE,   1'b0},
            '{"1",      1'b0, V_NONE,   1'b0},
            '{"f",      1'b0, V_NONE,   1'b0},
            '{"3",      1'b0, V_NONE,   1'b0},
            '{CH_STAR,  1'b0, V_NONE,   1'b0},
            '{CH_LF,    1'b0, V_NONE,   1'b0}
        };
        line_clear();
        foreach (dir_tab[k]) stim_q.push_back(dir_tab[k]);
        while (n_rand < RANDOM_BYTES) begin
            gen_line(n_lines == 3 || n_lines == 30 || $urandom_range(0, 99) < 2);
            n_lines++;
        end

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // sample at the falling edge so the sender's updates have settled
        @(negedge i_clk);
        while (stim_q.size() != 0 || i_valid) @(negedge i_clk);
        while (pending_verdicts.size() != 0) @(negedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("Sent %0d bytes (%0d random bytes in %0d lines), %0d line overflows.",
            n_sent, n_rand, n_lines, n_overflow);
        $display("Checked %0d verdicts: %0d checksum matches, %0d lines without a marker.",
            n_checked, n_pass_sum, n_no_marker);
        if (n_err == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("%0d mismatches in total", n_err);
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #(2 * HALF_PERIOD * TIMEOUT_CYCLES);
        $display("timeout: %0d verdicts still outstanding", pending_verdicts.size());
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
